FILE: hdl/lcs_pkg.sv
// Shared types and constants for the link connection supervisor.
// No dependencies; imported by lcs_step and link_connection_supervisor_core.
package lcs_pkg;

  // Procedure state, one-hot inside the block
  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_CONNECTING = 5'b00010,
    ST_CONNECTED  = 5'b00100,
    ST_FAILED     = 5'b01000,
    ST_BACKOFF    = 5'b10000
  } proc_state_e;

  // State codes as seen on the result port
  localparam logic [2:0] CODE_IDLE       = 3'd0;
  localparam logic [2:0] CODE_CONNECTING = 3'd1;
  localparam logic [2:0] CODE_CONNECTED  = 3'd2;
  localparam logic [2:0] CODE_FAILED     = 3'd3;
  localparam logic [2:0] CODE_BACKOFF    = 3'd4;

  // Link status codes (3-bit signed)
  localparam logic signed [2:0] LINK_DOWN    = 3'sd0;
  localparam logic signed [2:0] LINK_JOIN    = 3'sd1;
  localparam logic signed [2:0] LINK_NOIP    = 3'sd2;
  localparam logic signed [2:0] LINK_UP      = 3'sd3;
  localparam logic signed [2:0] LINK_BADAUTH = -3'sd3;

  // Register indexes
  localparam logic [2:0] REG_BAD_AUTH_LIMIT   = 3'd0;
  localparam logic [2:0] REG_CONNECT_TIMEOUT  = 3'd1;
  localparam logic [2:0] REG_RETRY_WAIT       = 3'd2;
  localparam logic [2:0] REG_BAD_AUTH_WAIT    = 3'd3;

  // Register reset values
  localparam logic [7:0]  RST_BAD_AUTH_LIMIT  = 8'd3;
  localparam logic [15:0] RST_CONNECT_TIMEOUT = 16'd300;
  localparam logic [15:0] RST_RETRY_WAIT      = 16'd100;
  localparam logic [15:0] RST_BAD_AUTH_WAIT   = 16'd1200;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;
  localparam logic [7:0]  AUTH_MAX = 8'hFF;

  // Configuration registers
  typedef struct packed {
    logic [7:0]  bad_auth_limit;
    logic [15:0] connect_timeout_ticks;
    logic [15:0] retry_wait_ticks;
    logic [15:0] bad_auth_wait_ticks;
  } cfg_t;

  // Supervisor state after one tick
  typedef struct packed {
    proc_state_e state;
    logic [15:0] tick_count;
    logic [7:0]  auth_fail_count;
    logic        request;
  } step_t;

  function automatic logic [2:0] state_code(proc_state_e st);
    logic [2:0] code;
    case (st)
      ST_IDLE:       code = CODE_IDLE;
      ST_CONNECTING: code = CODE_CONNECTING;
      ST_CONNECTED:  code = CODE_CONNECTED;
      ST_FAILED:     code = CODE_FAILED;
      ST_BACKOFF:    code = CODE_BACKOFF;
      default:       code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/lcs_step.sv
// Next-state logic for one supervision tick of the connect procedure.
// Depends on lcs_pkg.
module lcs_step
  import lcs_pkg::*;
(
  input  cfg_t              cfg_i,
  input  proc_state_e       state_i,
  input  logic [15:0]       tick_i,
  input  logic [7:0]        auth_i,
  input  logic signed [2:0] link_code_i,
  input  logic              start_fails_i,
  output step_t             step_o
);

  logic [15:0] tick_inc;
  logic [7:0]  auth_inc;
  logic        link_neg;

  // saturating increments
  assign tick_inc = (tick_i < TICK_MAX) ? tick_i + 16'd1 : tick_i;
  assign auth_inc = (auth_i < AUTH_MAX) ? auth_i + 8'd1 : auth_i;
  assign link_neg = link_code_i[2];

  always_comb begin
    step_o.state           = state_i;
    step_o.tick_count      = tick_i;
    step_o.auth_fail_count = auth_i;
    step_o.request         = 1'b0;
    case (state_i)
      ST_IDLE: begin
        if (link_code_i != LINK_DOWN) begin
          step_o.state = ST_FAILED;
        end else begin
          step_o.request = 1'b1;
          step_o.state   = start_fails_i ? ST_FAILED : ST_CONNECTING;
        end
      end
      ST_CONNECTING: begin
        if (link_code_i == LINK_UP) begin
          step_o.auth_fail_count = '0;
          step_o.state           = ST_CONNECTED;
        end else if (link_code_i == LINK_BADAUTH) begin
          step_o.auth_fail_count = auth_inc;
          step_o.state           = ST_FAILED;
        end else if (link_neg) begin
          step_o.state = ST_FAILED;
        end else if (link_code_i == LINK_JOIN || link_code_i == LINK_NOIP) begin
          // join / no-ip: wait for the connect timeout
          if (tick_i > cfg_i.connect_timeout_ticks) begin
            step_o.tick_count = '0;
            step_o.state      = ST_FAILED;
          end else begin
            step_o.tick_count = tick_inc;
          end
        end else begin
          step_o.state = ST_FAILED;
        end
      end
      ST_CONNECTED: begin
        if (link_code_i == LINK_UP) begin
          step_o.auth_fail_count = '0;
        end else begin
          step_o.state = ST_FAILED;
        end
      end
      ST_FAILED: begin
        if (link_code_i == LINK_UP) begin
          step_o.state = ST_CONNECTED;
        end else if (auth_i > cfg_i.bad_auth_limit) begin
          step_o.state = ST_BACKOFF;
        end else if (tick_i > cfg_i.retry_wait_ticks) begin
          // retry
          step_o.tick_count = '0;
          step_o.request    = 1'b1;
          step_o.state      = start_fails_i ? ST_FAILED : ST_CONNECTING;
        end else begin
          step_o.tick_count = tick_inc;
        end
      end
      ST_BACKOFF: begin
        // count first, then compare the new value
        if (tick_inc > cfg_i.bad_auth_wait_ticks) begin
          step_o.tick_count = '0;
          step_o.state      = ST_CONNECTING;
        end else begin
          step_o.tick_count = tick_inc;
        end
      end
      default: begin
        step_o.state = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/link_connection_supervisor_core.sv
// Link connection supervisor: one supervision tick in, one result out.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one tick beat: the link
//   status code and the start_fails flag. Output channel (out_valid_o /
//   out_stall_i) returns one result beat per tick: procedure state after the
//   tick, the connect request flag and the bad-auth count.
//   A beat moves on a rising edge with valid high and stall low.
//   The result of a tick is registered and is valid right after the edge
//   that takes it. Throughput is one tick per cycle while the result is not
//   stalled; the procedure state, tick counter and auth counter update in
//   the same edge that takes the tick, so the next tick sees them at once.
//   When the receiver stalls, the result register holds and in_stall_o rises
//   in the same cycle; a new tick is taken as soon as the result leaves.
//   Configuration (cfg_valid_i / cfg_ready_o, index + data) is always ready;
//   indexes above 3 are ignored. Write it only while the block is idle.
//   Reset (rst_ni low, async) returns the procedure to idle, clears both
//   counters, loads default register values and empties the result register.
// Depends on lcs_pkg and lcs_step.
module link_connection_supervisor_core
  import lcs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // tick input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic signed [2:0] link_code_i,
  input  logic              start_fails_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        procedure_state_o,
  output logic              connect_request_o,
  output logic [7:0]        auth_failures_o,
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  cfg_t        cfg_q;
  proc_state_e state_q;
  logic [15:0] tick_q;
  logic [7:0]  auth_q;
  step_t       step;
  logic        out_valid_q;
  logic [2:0]  res_state_q;
  logic        res_request_q;
  logic [7:0]  res_auth_q;
  logic        in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bad_auth_limit        <= RST_BAD_AUTH_LIMIT;
      cfg_q.connect_timeout_ticks <= RST_CONNECT_TIMEOUT;
      cfg_q.retry_wait_ticks      <= RST_RETRY_WAIT;
      cfg_q.bad_auth_wait_ticks   <= RST_BAD_AUTH_WAIT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BAD_AUTH_LIMIT:  cfg_q.bad_auth_limit        <= cfg_data_i[7:0];
        REG_CONNECT_TIMEOUT: cfg_q.connect_timeout_ticks <= cfg_data_i;
        REG_RETRY_WAIT:      cfg_q.retry_wait_ticks      <= cfg_data_i;
        REG_BAD_AUTH_WAIT:   cfg_q.bad_auth_wait_ticks   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lcs_step u_step (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .tick_i        (tick_q),
    .auth_i        (auth_q),
    .link_code_i   (link_code_i),
    .start_fails_i (start_fails_i),
    .step_o        (step)
  );

  // procedure state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tick_q  <= '0;
      auth_q  <= '0;
    end else if (in_fire) begin
      state_q <= step.state;
      tick_q  <= step.tick_count;
      auth_q  <= step.auth_fail_count;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_state_q   <= state_code(step.state);
      res_request_q <= step.request;
      res_auth_q    <= step.auth_fail_count;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign procedure_state_o = res_state_q;
  assign connect_request_o = res_request_q;
  assign auth_failures_o   = res_auth_q;

endmodule
